/* hw/rtl/fpp_pkg.sv */
// Shared types, codes and helper functions of the four-phase pixel PWM block.
package fpp_pkg;

  // Number of groups that appear on the result beat.
  localparam int unsigned OutGroups = 3;
  // Highest duty in percent that the level stores keep.
  localparam logic [6:0] DutyCap = 7'd100;

  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_SET_GROUP = 3'd1,
    MODE_LOW_BEAM  = 3'd2,
    MODE_FOG       = 3'd3,
    MODE_ALL_OFF   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  group_sel;
    logic [31:0] pixel_command;
    logic [7:0]  duty_request;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] mask_group0;
    logic [7:0] mask_group1;
    logic [7:0] mask_group2;
    logic       enable_group0;
    logic       enable_group1;
    logic       enable_group2;
    logic [6:0] low_beam_level;
    logic [6:0] fog_level;
    logic [1:0] phase_used;
  } out_beat_t;

  // Saturates an 8-bit percent request at the duty cap.
  function automatic logic [6:0] clamp_duty(input logic [7:0] duty);
    logic [6:0] res;
    res = (duty > {1'b0, DutyCap}) ? DutyCap : duty[6:0];
    return res;
  endfunction

  // Pixels lit in a phase: the 100% set always, shorter duties drop out as
  // the frame advances.
  function automatic logic [7:0] phase_mask(input logic [31:0] sets, input logic [1:0] phase);
    logic [7:0] m;
    m = sets[31:24];
    if (phase <= 2'd2) m = m | sets[23:16];
    if (phase <= 2'd1) m = m | sets[15:8];
    if (phase == 2'd0) m = m | sets[7:0];
    return m;
  endfunction

endpackage

/* hw/rtl/fpp_in_reg.sv */
// Input register stage of the four-phase pixel PWM block.
module fpp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fpp_pkg::in_beat_t data_i,
  input  logic              advance_i,
  output logic              valid_o,
  output fpp_pkg::in_beat_t data_o
);

  logic              valid_q, valid_d;
  fpp_pkg::in_beat_t data_q;

  // The stage takes a beat when empty or when its content moves on.
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/fpp_core.sv */
// Command stores, PWM phase logic and result register of the pixel PWM block.
module fpp_core #(
  parameter int unsigned GROUPS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  fpp_pkg::in_beat_t  item_i,
  output fpp_pkg::out_beat_t result_o
);

  logic [31:0] req_q     [GROUPS];
  logic [31:0] req_d     [GROUPS];
  logic [31:0] active_q  [GROUPS];
  logic [31:0] active_d  [GROUPS];
  logic [7:0]  mask_q    [GROUPS];
  logic [7:0]  mask_d    [GROUPS];
  logic [GROUPS-1:0] pending_q, pending_d;
  logic [GROUPS-1:0] en_q, en_d;
  logic [1:0]  phase_q, phase_d;
  logic [1:0]  last_q, last_d;
  logic [6:0]  low_q, low_d;
  logic [6:0]  fog_q, fog_d;
  fpp_pkg::out_beat_t res_q, res_d;

  logic [7:0] mask_vis [fpp_pkg::OutGroups];
  logic       en_vis   [fpp_pkg::OutGroups];

  always_comb begin
    req_d     = req_q;
    active_d  = active_q;
    mask_d    = mask_q;
    pending_d = pending_q;
    en_d      = en_q;
    phase_d   = phase_q;
    last_d    = last_q;
    low_d     = low_q;
    fog_d     = fog_q;
    if (step_i) begin
      case (item_i.mode)
        fpp_pkg::MODE_TICK: begin
          for (int g = 0; g < GROUPS; g++) begin
            if (phase_q == 2'd0 && pending_q[g]) begin
              active_d[g]  = req_q[g];
              pending_d[g] = 1'b0;
            end
            mask_d[g] = fpp_pkg::phase_mask(active_d[g], phase_q);
            en_d[g]   = (active_d[g] != 32'd0);
          end
          last_d  = phase_q;
          phase_d = phase_q + 2'd1;
        end
        fpp_pkg::MODE_SET_GROUP: begin
          // A group number beyond the configured count is ignored.
          for (int g = 0; g < GROUPS; g++) begin
            if (int'(item_i.group_sel) == g) begin
              req_d[g]     = item_i.pixel_command;
              pending_d[g] = 1'b1;
            end
          end
        end
        fpp_pkg::MODE_LOW_BEAM: begin
          low_d = fpp_pkg::clamp_duty(item_i.duty_request);
        end
        fpp_pkg::MODE_FOG: begin
          fog_d = fpp_pkg::clamp_duty(item_i.duty_request);
        end
        fpp_pkg::MODE_ALL_OFF: begin
          for (int g = 0; g < GROUPS; g++) begin
            req_d[g]    = 32'd0;
            active_d[g] = 32'd0;
            mask_d[g]   = 8'd0;
          end
          pending_d = '0;
          en_d      = '0;
          low_d     = 7'd0;
          fog_d     = 7'd0;
          phase_d   = 2'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // Groups that the configuration does not have read as zero.
  for (genvar g = 0; g < fpp_pkg::OutGroups; g++) begin : g_vis
    if (g < GROUPS) begin : g_have
      assign mask_vis[g] = mask_d[g];
      assign en_vis[g]   = en_d[g];
    end else begin : g_none
      assign mask_vis[g] = 8'd0;
      assign en_vis[g]   = 1'b0;
    end
  end

  always_comb begin
    res_d.mask_group0    = mask_vis[0];
    res_d.mask_group1    = mask_vis[1];
    res_d.mask_group2    = mask_vis[2];
    res_d.enable_group0  = en_vis[0];
    res_d.enable_group1  = en_vis[1];
    res_d.enable_group2  = en_vis[2];
    res_d.low_beam_level = low_d;
    res_d.fog_level      = fog_d;
    res_d.phase_used     = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) begin
        req_q[g]    <= 32'd0;
        active_q[g] <= 32'd0;
        mask_q[g]   <= 8'd0;
      end
      pending_q <= '0;
      en_q      <= '0;
      phase_q   <= 2'd0;
      last_q    <= 2'd0;
      low_q     <= 7'd0;
      fog_q     <= 7'd0;
    end else begin
      req_q     <= req_d;
      active_q  <= active_d;
      mask_q    <= mask_d;
      pending_q <= pending_d;
      en_q      <= en_d;
      phase_q   <= phase_d;
      last_q    <= last_d;
      low_q     <= low_d;
      fog_q     <= fog_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

  a_all_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == fpp_pkg::MODE_ALL_OFF
    |=> phase_q == 2'd0 && pending_q == '0 && en_q == '0 && low_q == 7'd0 && fog_q == 7'd0)
    else $error("all-off command left state behind");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == fpp_pkg::MODE_TICK
    |=> phase_q == $past(phase_q) + 2'd1 && last_q == $past(phase_q))
    else $error("tick did not advance the frame phase");

  a_frame_start_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode == fpp_pkg::MODE_TICK && phase_q == 2'd0
    |=> pending_q == '0)
    else $error("pending command survived a frame start");

  a_levels_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= fpp_pkg::DutyCap && fog_q <= fpp_pkg::DutyCap)
    else $error("stored duty above cap");

endmodule

/* hw/rtl/four_phase_pixel_pwm.sv */
// Top level of the four-phase pixel PWM block with double-buffered group commands.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | to block  | in_valid_i / in_ready_o | fpp_pkg::in_beat_t  in_data_i
//   out     | from block| out_valid_o/ out_ready_i| fpp_pkg::out_beat_t out_data_o
//
// Every accepted input beat yields exactly one result beat: it passes the input
// register, then goes through the state update into the result register. The
// block sustains one beat per cycle while the output is not stalled; its rate
// is set by the state update in the core. Reset (rst_ni, asynchronous, low)
// clears all command stores, flags, masks, levels and the phase counter.
// When the output is stalled, the result register and then the input register
// hold their beats, and in_ready_o drops once both are full.
module four_phase_pixel_pwm #(
  parameter int unsigned GROUPS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fpp_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fpp_pkg::out_beat_t out_data_o
);

  logic              s1_valid;
  fpp_pkg::in_beat_t s1_data;
  logic              advance;
  logic              out_valid_q, out_valid_d;

  // A beat leaves the input register when the result register is free or
  // its current beat is being taken in this same cycle.
  assign advance = s1_valid && (!out_valid_q || out_ready_i);

  fpp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .data_i    (in_data_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .data_o    (s1_data)
  );

  // The core applies the beat to the state and captures the result.
  fpp_core #(
    .GROUPS (GROUPS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_data),
    .result_o (out_data_o)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step taken without a result beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("pending result beat overwritten");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full");

endmodule
